// ===== src/spr_pkg.sv =====
// ============================================================================
// spr_pkg - slotted page record store shared definitions
// Page geometry, slot directory entry layout, request and status codes.
// ============================================================================
`default_nettype none

package spr_pkg;

    // Page geometry
    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 20;
    localparam int MAX_SLOTS    = 512;
    localparam int SLOT_COST    = 8;

    localparam int ADDR_W = $clog2(PAGE_BYTES);      // page byte address
    localparam int PTR_W  = $clog2(PAGE_BYTES + 1);  // offsets, lengths, free pointer
    localparam int SLOT_W = $clog2(MAX_SLOTS);       // slot number
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);   // used slot count
    localparam int NEED_W = PTR_W + 2;               // space check sum

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_READ   = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_DELETE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_NO_SPACE      = 3'd1,
        ST_BAD_SLOT      = 3'd2,
        ST_DELETED       = 3'd3,
        ST_SIZE_MISMATCH = 3'd4,
        ST_BEYOND        = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [PTR_W-1:0] offset;
        logic [PTR_W-1:0] length;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    // Index past the end of a record; index 0 of an empty record is in range.
    function automatic logic beyond(input logic [ADDR_W-1:0] idx,
                                    input logic [PTR_W-1:0]  len);
        logic res;
        if (len == '0)
            res = (idx != '0);
        else
            res = ({1'b0, idx} >= len);
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/spr_ram.sv =====
// ============================================================================
// spr_ram - generic synchronous RAM
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module spr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/slotted_page_record_store_core.sv =====
// ============================================================================
// slotted_page_record_store_core - slotted page record store
// One page of records streamed a byte per request, with a slot directory.
// ============================================================================
// A request is taken when start is high and busy is low; it passes through
// the lookup state, which reads the slot directory memory, and the execute
// state, which checks and accesses the page memory, and its result, with
// the registered page read data, appears on the result ports with done high
// for exactly one cycle; the receiver cannot stall, so results must be
// taken as they come. A new request may be issued in the cycle done is
// high. The directory and page memories are not cleared at reset; bytes
// of a record that were never streamed in read back as arbitrary data.
// own_page_number is written through the cfg channel, which is ready
// whenever busy is low.
`default_nettype none

module slotted_page_record_store_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [8:0]  slot,
    input  logic [12:0] record_size,
    input  logic [11:0] byte_index,
    input  logic [7:0]  byte_value,
    output logic        done,
    output logic [2:0]  status,
    output logic [8:0]  slot_out,
    output logic [31:0] page_out,
    output logic [7:0]  byte_out,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int ADDR_W  = spr_pkg::ADDR_W;
    localparam int PTR_W   = spr_pkg::PTR_W;
    localparam int SLOT_W  = spr_pkg::SLOT_W;
    localparam int CNT_W   = spr_pkg::CNT_W;
    localparam int NEED_W  = spr_pkg::NEED_W;
    localparam int ENTRY_W = spr_pkg::ENTRY_W;

    // control state
    spr_pkg::state_t   state_reg, state_next;
    logic [PTR_W-1:0]  free_reg, free_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [PTR_W-1:0]  pend_off_reg, pend_off_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic              pend_fail_reg, pend_fail_next;
    logic [31:0]       own_page_reg;

    // latched request
    spr_pkg::kind_t    kind_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [12:0]       size_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [7:0]        val_reg;

    // result
    spr_pkg::status_t  status_reg, status_next;
    logic [SLOT_W-1:0] slot_out_reg, slot_out_next;
    logic              last_reg, last_next;
    logic              rd_ok_reg, rd_ok_next;

    logic accept;

    // slot directory
    logic                tbl_we;
    logic [SLOT_W-1:0]   tbl_waddr;
    spr_pkg::slot_entry_t tbl_wentry;
    logic                tbl_re;
    logic [SLOT_W-1:0]   tbl_raddr;
    logic [ENTRY_W-1:0]  tbl_rdata;
    spr_pkg::slot_entry_t entry;

    // page bytes
    logic              page_we;
    logic              page_re;
    logic [ADDR_W-1:0] page_addr;
    logic [7:0]        page_rdata;

    // execute helpers
    logic [NEED_W-1:0] need;
    logic              fits;
    logic [PTR_W-1:0]  ins_len;
    logic [PTR_W-1:0]  idx_p1;
    logic              last_sz;
    logic              slot_ok;
    logic [PTR_W-1:0]  base;
    logic [PTR_W-1:0]  addr_sum;

    assign accept    = start && !busy;
    assign busy      = (state_reg == spr_pkg::S_LOOK) || (state_reg == spr_pkg::S_EXEC);
    assign cfg_ready = !busy;

    assign done     = (state_reg == spr_pkg::S_OUT);
    assign status   = status_reg;
    assign slot_out = slot_out_reg;
    assign page_out = own_page_reg;
    assign byte_out = rd_ok_reg ? page_rdata : 8'd0;
    assign last     = last_reg;

    assign entry = spr_pkg::slot_entry_t'(tbl_rdata);

    // space check: free pointer must cover header, directory, new slot and data
    assign need = NEED_W'(spr_pkg::HEADER_BYTES)
                + {2'b00, used_reg, 3'b000}
                + {2'b00, size_reg}
                + NEED_W'(spr_pkg::SLOT_COST);
    assign fits = (used_reg < CNT_W'(spr_pkg::MAX_SLOTS)) && ({2'b00, free_reg} >= need);

    // first insert byte: the directory entry was allocated in the lookup cycle
    assign ins_len  = (idx_reg == '0) ? size_reg : entry.length;
    assign idx_p1   = {1'b0, idx_reg} + PTR_W'(1);
    assign last_sz  = (idx_p1 >= size_reg);
    assign slot_ok  = ({1'b0, slot_reg} < used_reg);
    assign base     = (kind_reg == spr_pkg::KIND_INSERT) ? pend_off_reg : entry.offset;
    assign addr_sum = base + {1'b0, idx_reg};
    assign page_addr = addr_sum[ADDR_W-1:0];

    assign tbl_raddr = (kind_reg == spr_pkg::KIND_INSERT) ? pend_slot_reg : slot_reg;
    assign tbl_re    = (state_reg == spr_pkg::S_LOOK);

    always_comb
    begin
        state_next     = state_reg;
        free_next      = free_reg;
        used_next      = used_reg;
        pend_off_next  = pend_off_reg;
        pend_slot_next = pend_slot_reg;
        pend_fail_next = pend_fail_reg;
        status_next    = status_reg;
        slot_out_next  = slot_out_reg;
        last_next      = last_reg;
        rd_ok_next     = rd_ok_reg;
        tbl_we         = 1'b0;
        tbl_waddr      = slot_reg;
        tbl_wentry     = entry;
        page_we        = 1'b0;
        page_re        = 1'b0;

        unique case (state_reg)
            spr_pkg::S_IDLE,
            spr_pkg::S_OUT:
            begin
                state_next = accept ? spr_pkg::S_LOOK : spr_pkg::S_IDLE;
            end

            spr_pkg::S_LOOK:
            begin
                state_next = spr_pkg::S_EXEC;
                if (kind_reg == spr_pkg::KIND_INSERT && idx_reg == '0)
                begin
                    pend_fail_next = !fits;
                    if (fits)
                    begin
                        free_next         = free_reg - size_reg;
                        pend_off_next     = free_reg - size_reg;
                        pend_slot_next    = used_reg[SLOT_W-1:0];
                        used_next         = used_reg + CNT_W'(1);
                        tbl_we            = 1'b1;
                        tbl_waddr         = used_reg[SLOT_W-1:0];
                        tbl_wentry.offset = free_reg - size_reg;
                        tbl_wentry.length = size_reg;
                    end
                end
            end

            spr_pkg::S_EXEC:
            begin
                state_next    = spr_pkg::S_OUT;
                status_next   = spr_pkg::ST_OK;
                slot_out_next = slot_reg;
                last_next     = 1'b1;
                rd_ok_next    = 1'b0;
                unique case (kind_reg)
                    spr_pkg::KIND_INSERT:
                    begin
                        last_next = last_sz;
                        if (pend_fail_reg || ({1'b0, pend_slot_reg} >= used_reg))
                        begin
                            status_next = spr_pkg::ST_NO_SPACE;
                        end
                        else if (spr_pkg::beyond(idx_reg, ins_len))
                        begin
                            status_next = spr_pkg::ST_BEYOND;
                            last_next   = 1'b1;
                        end
                        else
                        begin
                            slot_out_next = pend_slot_reg;
                            page_we       = (ins_len != '0);
                        end
                    end
                    spr_pkg::KIND_READ:
                    begin
                        if (!slot_ok)
                        begin
                            status_next = spr_pkg::ST_BAD_SLOT;
                        end
                        else if (entry.length == '0)
                        begin
                            status_next = spr_pkg::ST_DELETED;
                        end
                        else if ({1'b0, idx_reg} >= entry.length)
                        begin
                            status_next = spr_pkg::ST_BEYOND;
                        end
                        else
                        begin
                            page_re    = 1'b1;
                            rd_ok_next = 1'b1;
                            last_next  = (idx_p1 >= entry.length);
                        end
                    end
                    spr_pkg::KIND_UPDATE:
                    begin
                        last_next = last_sz;
                        if (!slot_ok)
                        begin
                            status_next = spr_pkg::ST_BAD_SLOT;
                        end
                        else if (entry.length != size_reg)
                        begin
                            status_next = spr_pkg::ST_SIZE_MISMATCH;
                        end
                        else if (spr_pkg::beyond(idx_reg, size_reg))
                        begin
                            status_next = spr_pkg::ST_BEYOND;
                            last_next   = 1'b1;
                        end
                        else
                        begin
                            page_we = (size_reg != '0);
                        end
                    end
                    spr_pkg::KIND_DELETE:
                    begin
                        if (!slot_ok)
                        begin
                            status_next = spr_pkg::ST_BAD_SLOT;
                        end
                        else
                        begin
                            // tombstone: keep offset, zero length
                            tbl_we            = 1'b1;
                            tbl_waddr         = slot_reg;
                            tbl_wentry.length = '0;
                        end
                    end
                    default:
                    begin
                        status_next = spr_pkg::ST_OK;
                    end
                endcase
            end

            default:
            begin
                state_next = spr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spr_pkg::S_IDLE;
            free_reg      <= PTR_W'(spr_pkg::PAGE_BYTES);
            used_reg      <= '0;
            pend_off_reg  <= '0;
            pend_slot_reg <= '0;
            pend_fail_reg <= 1'b0;
            own_page_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            used_reg      <= used_next;
            pend_off_reg  <= pend_off_next;
            pend_slot_reg <= pend_slot_next;
            pend_fail_reg <= pend_fail_next;
            if (cfg_valid && cfg_ready)
            begin
                own_page_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= spr_pkg::kind_t'(kind);
            slot_reg <= slot;
            size_reg <= record_size;
            idx_reg  <= byte_index;
            val_reg  <= byte_value;
        end
        status_reg   <= status_next;
        slot_out_reg <= slot_out_next;
        last_reg     <= last_next;
        rd_ok_reg    <= rd_ok_next;
    end

    spr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (spr_pkg::MAX_SLOTS)
    ) u_slot_dir (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wentry),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    spr_ram #(
        .WIDTH (8),
        .DEPTH (spr_pkg::PAGE_BYTES)
    ) u_page (
        .clk   (clk),
        .we    (page_we),
        .waddr (page_addr),
        .wdata (val_reg),
        .re    (page_re),
        .raddr (page_addr),
        .rdata (page_rdata)
    );

    // assertions
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && (state_reg == spr_pkg::S_LOOK))
        else $error("accepted request did not start lookup");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(spr_pkg::MAX_SLOTS))
        else $error("slot count beyond directory size");

    a_space: assert property (@(posedge clk) disable iff (!rst_n)
        {2'b00, free_reg} >= (NEED_W'(spr_pkg::HEADER_BYTES) + {2'b00, used_reg, 3'b000}))
        else $error("record area overlaps slot directory");

    a_page_access: assert property (@(posedge clk) disable iff (!rst_n)
        (page_we || page_re || (tbl_we && kind_reg == spr_pkg::KIND_DELETE))
            |-> (state_reg == spr_pkg::S_EXEC))
        else $error("page or tombstone write outside execute cycle");

endmodule

`default_nettype wire
